/* src/fbfl_pkg.sv */
// shared constants, types and helpers of the fixed block free list allocator
package fbfl_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int MAX_BLOCKS  = 512;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int LINK_W      = IDX_W + 1;
  localparam int COUNT_W     = 10;
  localparam int COUNT_MAX   = 1023;
  localparam int ADDR_W      = 12;
  localparam int SIZE_W      = 16;
  localparam int SHIFT_W     = 4;
  localparam int SHIFT_LOW   = 3;
  localparam int SHIFT_HIGH  = 12;
  localparam int SHIFT_RESET = 5;
  localparam int PAGE_W      = $clog2(PAGE_BYTES) + 1;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_TOO_LARGE = 2'd2,
    STATUS_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] r;
    r = s;
    if (r < SHIFT_W'(SHIFT_LOW)) r = SHIFT_W'(SHIFT_LOW);
    if (r > SHIFT_W'(SHIFT_HIGH)) r = SHIFT_W'(SHIFT_HIGH);
    return r;
  endfunction

  // number of blocks in the page for a clamped shift, capped at the list depth
  function automatic logic [COUNT_W-1:0] block_count_of(input logic [SHIFT_W-1:0] s);
    logic [PAGE_W-1:0] n;
    n = PAGE_W'(PAGE_BYTES) >> s;
    if (n > PAGE_W'(MAX_BLOCKS)) n = PAGE_W'(MAX_BLOCKS);
    return COUNT_W'(n);
  endfunction

endpackage

/* src/fbfl_req_if.sv */
// request channel: allocate or free
interface fbfl_req_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [fbfl_pkg::SIZE_W-1:0]     request_size;
  logic [fbfl_pkg::ADDR_W-1:0]     free_address;
  logic                            address_present;

  modport source (output valid, mode, request_size, free_address, address_present,
                  input ready);
  modport sink (input valid, mode, request_size, free_address, address_present,
                output ready);
endinterface

/* src/fbfl_rsp_if.sv */
// response channel: block address, status and free count
interface fbfl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fbfl_pkg::ADDR_W-1:0]      block_address;
  logic [1:0]                       status;
  logic [fbfl_pkg::COUNT_W-1:0]     blocks_free;

  modport source (output valid, block_address, status, blocks_free, input ready);
  modport sink (input valid, block_address, status, blocks_free, output ready);
endinterface

/* src/fixed_block_free_list_allocator.sv */
// fixed size block allocator over one page with a lifo free list in ram
//
//  channel  dir  signals                                              transfer when
//  req      in   mode, request_size, free_address, address_present    valid & ready
//  rsp      out  block_address, status, blocks_free                   valid & ready
//  cfg      in   cfg_data (block_shift)                                cfg_write
//
// a request is accepted in idle; in the exec state the link ram read of the head block
// has returned and the head, count and link are updated while the response registers.
// after reset and after every cfg write a pass rebuilds the chain in the link ram,
// one entry a cycle over all MAX_BLOCKS (512) entries; no request is taken meanwhile.
// a response waiting on rsp does not block the next accept; the second request
// holds in its update cycle until the response register frees up.
module fixed_block_free_list_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fbfl_pkg::SHIFT_W-1:0]  cfg_data,
  fbfl_req_if.sink                      req,
  fbfl_rsp_if.source                    rsp
);

  localparam int IDX_W   = fbfl_pkg::IDX_W;
  localparam int LINK_W  = fbfl_pkg::LINK_W;
  localparam int COUNT_W = fbfl_pkg::COUNT_W;
  localparam int ADDR_W  = fbfl_pkg::ADDR_W;
  localparam int SIZE_W  = fbfl_pkg::SIZE_W;
  localparam int SHIFT_W = fbfl_pkg::SHIFT_W;
  localparam int PAGE_W  = fbfl_pkg::PAGE_W;

  localparam logic [SHIFT_W-1:0] RESET_SHIFT =
    fbfl_pkg::eff_shift(SHIFT_W'(fbfl_pkg::SHIFT_RESET));
  localparam logic [COUNT_W-1:0] RESET_COUNT = fbfl_pkg::block_count_of(RESET_SHIFT);
  localparam logic [IDX_W-1:0]   SWEEP_LAST  = IDX_W'(fbfl_pkg::MAX_BLOCKS - 1);

  fbfl_pkg::state_t state, state_next;

  logic [SHIFT_W-1:0] shift, shift_next;
  logic [COUNT_W-1:0] block_count, block_count_next;
  logic [IDX_W-1:0]   sweep_idx, sweep_idx_next;
  logic [IDX_W-1:0]   head_index, head_index_next;
  logic               head_is_null, head_is_null_next;
  logic [COUNT_W-1:0] free_total, free_total_next;

  // captured request
  logic               item_mode;
  logic [SIZE_W-1:0]  item_size;
  logic [ADDR_W-1:0]  item_faddr;
  logic               item_present;

  logic               out_valid, out_valid_next;
  logic [ADDR_W-1:0]  out_addr;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_free;

  logic               out_load;
  logic [ADDR_W-1:0]  res_addr;
  fbfl_pkg::status_t  res_status;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;

  logic [LINK_W-1:0]  sweep_link;
  logic [PAGE_W-1:0]  blk_bytes;
  logic [ADDR_W-1:0]  fidx_full;
  logic               req_xfer;

  assign req.ready = (state == fbfl_pkg::S_IDLE);
  assign req_xfer  = req.valid && req.ready;

  assign rsp.valid         = out_valid;
  assign rsp.block_address = out_addr;
  assign rsp.status        = out_status;
  assign rsp.blocks_free   = out_free;

  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (fbfl_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_index),
    .rdata (ram_rdata)
  );

  always_comb begin
    sweep_link = LINK_W'(sweep_idx) + LINK_W'(1);
    if (sweep_link >= LINK_W'(block_count)) begin
      sweep_link = fbfl_pkg::LINK_NULL;
    end
    blk_bytes = PAGE_W'(1) << shift;
    fidx_full = item_faddr >> shift;
  end

  always_comb begin
    state_next        = state;
    shift_next        = shift;
    block_count_next  = block_count;
    sweep_idx_next    = sweep_idx;
    head_index_next   = head_index;
    head_is_null_next = head_is_null;
    free_total_next   = free_total;
    out_load          = 1'b0;
    res_addr          = '0;
    res_status        = fbfl_pkg::STATUS_DONE;
    ram_we            = 1'b0;
    ram_waddr         = sweep_idx;
    ram_wdata         = sweep_link;

    case (state)
      fbfl_pkg::S_SWEEP: begin
        ram_we         = 1'b1;
        sweep_idx_next = sweep_idx + IDX_W'(1);
        if (sweep_idx == SWEEP_LAST) begin
          state_next = fbfl_pkg::S_IDLE;
        end
      end
      fbfl_pkg::S_IDLE: begin
        if (req_xfer) begin
          state_next = fbfl_pkg::S_EXEC;
        end
      end
      fbfl_pkg::S_EXEC: begin
        if (item_mode == fbfl_pkg::MODE_ALLOC) begin
          if (head_is_null || free_total == '0) begin
            res_status = fbfl_pkg::STATUS_EMPTY;
          end else if ({1'b0, item_size} > (SIZE_W + 1)'(blk_bytes)) begin
            res_status = fbfl_pkg::STATUS_TOO_LARGE;
          end else begin
            res_addr = ADDR_W'(ADDR_W'(head_index) << shift);
          end
        end else begin
          if (!item_present || fidx_full >= ADDR_W'(block_count)) begin
            res_status = fbfl_pkg::STATUS_IGNORED;
          end
        end
        out_load = !out_valid || rsp.ready;
        if (out_load) begin
          state_next = fbfl_pkg::S_IDLE;
          if (res_status == fbfl_pkg::STATUS_DONE) begin
            if (item_mode == fbfl_pkg::MODE_ALLOC) begin
              // ram data is the link of the head block read at accept
              if (ram_rdata >= fbfl_pkg::LINK_NULL) begin
                head_is_null_next = 1'b1;
                head_index_next   = '0;
              end else begin
                head_index_next = ram_rdata[IDX_W-1:0];
              end
              free_total_next = free_total - COUNT_W'(1);
            end else begin
              ram_we            = 1'b1;
              ram_waddr         = fidx_full[IDX_W-1:0];
              ram_wdata         = head_is_null ? fbfl_pkg::LINK_NULL : LINK_W'(head_index);
              head_index_next   = fidx_full[IDX_W-1:0];
              head_is_null_next = 1'b0;
              if (free_total < COUNT_W'(fbfl_pkg::COUNT_MAX)) begin
                free_total_next = free_total + COUNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
        state_next = fbfl_pkg::S_SWEEP;
      end
    endcase

    // a new block size rebuilds the whole pool
    if (cfg_write) begin
      shift_next        = fbfl_pkg::eff_shift(cfg_data);
      block_count_next  = fbfl_pkg::block_count_of(fbfl_pkg::eff_shift(cfg_data));
      free_total_next   = fbfl_pkg::block_count_of(fbfl_pkg::eff_shift(cfg_data));
      head_index_next   = '0;
      head_is_null_next = 1'b0;
      sweep_idx_next    = '0;
      state_next        = fbfl_pkg::S_SWEEP;
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fbfl_pkg::S_SWEEP;
      shift        <= RESET_SHIFT;
      block_count  <= RESET_COUNT;
      sweep_idx    <= '0;
      head_index   <= '0;
      head_is_null <= 1'b0;
      free_total   <= RESET_COUNT;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      shift        <= shift_next;
      block_count  <= block_count_next;
      sweep_idx    <= sweep_idx_next;
      head_index   <= head_index_next;
      head_is_null <= head_is_null_next;
      free_total   <= free_total_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item_mode    <= req.mode;
      item_size    <= req.request_size;
      item_faddr   <= req.free_address;
      item_present <= req.address_present;
    end
    if (out_load) begin
      out_addr   <= res_addr;
      out_status <= res_status;
      out_free   <= free_total_next;
    end
  end

  // a stalled update must not move the head, or the held ram read goes stale
  a_head_holds_in_stall: assert property (@(posedge clk) disable iff (rst)
    (state == fbfl_pkg::S_EXEC && !out_load && !cfg_write) |=> $stable(head_index))
    else $error("head moved while update stalled");

  a_alloc_decrements: assert property (@(posedge clk) disable iff (rst)
    (out_load && item_mode == fbfl_pkg::MODE_ALLOC &&
     res_status == fbfl_pkg::STATUS_DONE && !cfg_write)
    |=> free_total == $past(free_total) - COUNT_W'(1))
    else $error("allocate did not take one block off the count");

  a_exec_write_is_free: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == fbfl_pkg::S_EXEC) |-> (item_mode == fbfl_pkg::MODE_FREE && out_load))
    else $error("link ram written outside a completed free");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == fbfl_pkg::S_SWEEP && sweep_idx == SWEEP_LAST && !cfg_write)
    |=> state == fbfl_pkg::S_IDLE)
    else $error("rebuild pass did not finish after the last entry");

endmodule

/* src/fbfl_ram.sv */
// generic single write port, single read port ram with registered read
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/fbfl_pool_tracker.sv */
// shadow free list of the allocator: predicts each response and compares it on transfer
module fbfl_pool_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fbfl_pkg::SHIFT_W-1:0] cfg_data,
  fbfl_req_if                          req,
  fbfl_rsp_if                          rsp,
  output int                           mismatches,
  output int                           outstanding
);

  localparam int ADDR_W     = fbfl_pkg::ADDR_W;
  localparam int COUNT_W    = fbfl_pkg::COUNT_W;
  localparam int LINK_W     = fbfl_pkg::LINK_W;
  localparam int IDX_W      = fbfl_pkg::IDX_W;
  localparam int SIZE_W     = fbfl_pkg::SIZE_W;
  localparam int SHIFT_W    = fbfl_pkg::SHIFT_W;
  localparam int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS;

  typedef struct packed {
    logic [ADDR_W-1:0]  block_address;
    fbfl_pkg::status_t  status;
    logic [COUNT_W-1:0] blocks_free;
  } pool_answer_t;

  logic [LINK_W-1:0]  link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]   head;
  logic               list_empty;
  logic [COUNT_W-1:0] pool_free;
  logic [SHIFT_W-1:0] shift_reg;
  int unsigned        pool_blocks;
  pool_answer_t       awaited_answers [$];
  int                 fail_count = 0;
  int                 waiting_count = 0;

  assign mismatches  = fail_count;
  assign outstanding = waiting_count;

  function automatic int unsigned clamped_shift(logic [SHIFT_W-1:0] s);
    if (s < SHIFT_W'(3)) return 3;
    if (s > SHIFT_W'(12)) return 12;
    return int'(s);
  endfunction

  // every block free again, chained in address order from block 0
  task automatic rebuild_pool(logic [SHIFT_W-1:0] s);
    int unsigned n;
    shift_reg = s;
    n = 4096 >> clamped_shift(s);
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    pool_blocks = n;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      link_mem[i] = (i + 1 < n) ? LINK_W'(i + 1) : fbfl_pkg::LINK_NULL;
    end
    head       = '0;
    list_empty = (n == 0);
    pool_free  = COUNT_W'(n);
  endtask

  function automatic pool_answer_t apply_request(logic mode, logic [SIZE_W-1:0] size,
                                                 logic [ADDR_W-1:0] faddr, logic present);
    pool_answer_t      r;
    int unsigned       sh;
    int unsigned       idx;
    int unsigned       head_val;
    logic [LINK_W-1:0] nxt;
    sh = clamped_shift(shift_reg);
    r.block_address = '0;
    r.status        = fbfl_pkg::STATUS_DONE;
    if (mode == fbfl_pkg::MODE_ALLOC) begin
      // empty list wins over the size check
      if (list_empty || pool_free == 0) begin
        r.status = fbfl_pkg::STATUS_EMPTY;
      end else if (32'(size) > (32'd1 << sh)) begin
        r.status = fbfl_pkg::STATUS_TOO_LARGE;
      end else begin
        head_val        = int'(head);
        nxt             = link_mem[head_val];
        r.block_address = ADDR_W'(head_val << sh);
        if (nxt >= fbfl_pkg::LINK_NULL) begin
          list_empty = 1'b1;
          head       = '0;
        end else begin
          head = nxt[IDX_W-1:0];
        end
        pool_free = pool_free - COUNT_W'(1);
      end
    end else begin
      idx = int'(faddr) >> sh;
      if (!present || idx >= pool_blocks) begin
        r.status = fbfl_pkg::STATUS_IGNORED;
      end else begin
        // no double free check: the block is simply pushed again
        link_mem[idx] = list_empty ? fbfl_pkg::LINK_NULL : LINK_W'(head);
        head          = IDX_W'(idx);
        list_empty    = 1'b0;
        if (pool_free < COUNT_W'(fbfl_pkg::COUNT_MAX)) pool_free = pool_free + COUNT_W'(1);
      end
    end
    r.blocks_free = pool_free;
    return r;
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    pool_answer_t want;
    if (rst) begin
      rebuild_pool(SHIFT_W'(fbfl_pkg::SHIFT_RESET));
      awaited_answers.delete();
    end else begin
      // a response never shares its edge with its own request
      if (rsp.valid && rsp.ready) begin
        if (awaited_answers.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response: expected none, got address %0d status %0d free %0d",
                   $time, rsp.block_address, rsp.status, rsp.blocks_free);
        end else begin
          want = awaited_answers.pop_front();
          compare_field("block_address", want.block_address, rsp.block_address);
          compare_field("status", want.status, rsp.status);
          compare_field("blocks_free", want.blocks_free, rsp.blocks_free);
        end
      end
      if (cfg_write) rebuild_pool(cfg_data);
      if (req.valid && req.ready) begin
        awaited_answers.push_back(apply_request(req.mode, req.request_size,
                                                req.free_address, req.address_present));
      end
    end
    waiting_count = awaited_answers.size();
  end

endmodule

/* tb/sv/fixed_block_free_list_allocator_tb.sv */
// stimulus and verdict for the fixed block free list allocator
module fixed_block_free_list_allocator_tb;

  localparam int SHIFT_W      = fbfl_pkg::SHIFT_W;
  localparam int ADDR_W       = fbfl_pkg::ADDR_W;
  localparam int SIZE_W       = fbfl_pkg::SIZE_W;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [SHIFT_W-1:0] cfg_data = '0;
  int                 mismatches;
  int                 outstanding;
  int unsigned        cycle_count = 0;

  fbfl_req_if req_ch ();
  fbfl_rsp_if rsp_ch ();

  // block offsets handed out and not yet returned, for well formed frees
  logic [ADDR_W-1:0] live_blocks [$];
  fbfl_pkg::mode_t   sent_modes [$];
  int unsigned       cur_shift = fbfl_pkg::SHIFT_RESET;
  int unsigned       burst_left = 0;
  bit                steady = 1'b1;

  fixed_block_free_list_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  fbfl_pool_tracker pool_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("fixed_block_free_list_allocator test failed");
      $finish;
    end
  end

  // remember which transfers were allocations so granted blocks can be freed later
  always @(posedge clk) begin
    fbfl_pkg::mode_t m;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready && sent_modes.size() > 0) begin
        m = sent_modes.pop_front();
        if (m == fbfl_pkg::MODE_ALLOC && rsp_ch.status == fbfl_pkg::STATUS_DONE) begin
          live_blocks.push_back(rsp_ch.block_address);
        end
      end
      if (req_ch.valid && req_ch.ready) sent_modes.push_back(fbfl_pkg::mode_t'(req_ch.mode));
    end
  end

  // receiver stalls follow a rotating pattern, reloaded now and then
  initial begin
    logic [15:0] ready_pattern;
    int unsigned pattern_age;
    rsp_ch.ready  = 1'b0;
    ready_pattern = 16'hFFFF;
    pattern_age   = 0;
    forever begin
      @(negedge clk);
      if (pattern_age == 0) begin
        case ($urandom_range(3))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'h0F0F;
          2:       ready_pattern = 16'($urandom) | 16'h8000;
          default: ready_pattern = 16'($urandom) | 16'($urandom);
        endcase
        pattern_age = $urandom_range(64, 16);
      end
      rsp_ch.ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_age--;
    end
  end

  task automatic issue(fbfl_pkg::mode_t m, logic [SIZE_W-1:0] size,
                       logic [ADDR_W-1:0] faddr, logic present);
    int unsigned gap;
    req_ch.valid           <= 1'b1;
    req_ch.mode            <= m;
    req_ch.request_size    <= size;
    req_ch.free_address    <= faddr;
    req_ch.address_present <= present;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady) begin
      gap        = $urandom_range(6, 1);
      burst_left = $urandom_range(16, 1);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold off until every response is in
  task automatic wait_quiet();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_shift(logic [SHIFT_W-1:0] s);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_data  <= s;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_shift = (s < 3) ? 3 : (s > 12) ? 12 : int'(s);
    live_blocks.delete();
  endtask

  task automatic random_item();
    int unsigned       pick;
    int unsigned       block_bytes;
    int unsigned       k;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] faddr;
    block_bytes = 1 << cur_shift;
    pick        = $urandom_range(99);
    if (pick < 50) begin
      if ($urandom_range(9) == 0) size = SIZE_W'($urandom);
      else size = SIZE_W'($urandom_range(block_bytes));
      issue(fbfl_pkg::MODE_ALLOC, size, ADDR_W'($urandom), 1'($urandom));
    end else if (pick < 88 && live_blocks.size() > 0) begin
      k     = $urandom_range(live_blocks.size() - 1);
      faddr = live_blocks[k];
      live_blocks.delete(k);
      // sometimes point inside the block rather than at its start
      if ($urandom_range(3) == 0) faddr = faddr | ADDR_W'($urandom_range(block_bytes - 1));
      issue(fbfl_pkg::MODE_FREE, SIZE_W'($urandom), faddr, 1'b1);
    end else begin
      // null frees and frees of arbitrary blocks, double frees among them
      issue(fbfl_pkg::MODE_FREE, SIZE_W'($urandom), ADDR_W'($urandom),
            1'($urandom_range(3) != 0));
    end
  endtask

  initial begin
    logic [SHIFT_W-1:0] phase_shifts [10];
    phase_shifts = '{4'd3, 4'd12, 4'd0, 4'd15, 4'd11, 4'd4, 4'd8, 4'd6, 4'd10, 4'd9};
    req_ch.valid           = 1'b0;
    req_ch.mode            = fbfl_pkg::MODE_ALLOC;
    req_ch.request_size    = '0;
    req_ch.free_address    = '0;
    req_ch.address_present = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset pool: 128 blocks of 32 bytes
    issue(fbfl_pkg::MODE_ALLOC, 16'd0, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'd32, 12'hFFF, 1'b1);
    issue(fbfl_pkg::MODE_ALLOC, 16'd33, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'hFFFF, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_FREE, 16'hFFFF, 12'hFFF, 1'b0);
    issue(fbfl_pkg::MODE_FREE, 16'd0, 12'd37, 1'b1);
    issue(fbfl_pkg::MODE_ALLOC, 16'd1, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_FREE, 16'd0, 12'd0, 1'b1);
    issue(fbfl_pkg::MODE_FREE, 16'd0, 12'd0, 1'b1);
    issue(fbfl_pkg::MODE_ALLOC, 16'd16, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'd16, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_FREE, 16'd0, 12'hFFF, 1'b1);

    // a single 4 KiB block: empty pool takes precedence over size
    set_shift(4'd12);
    issue(fbfl_pkg::MODE_ALLOC, 16'd4096, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'd0, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'hFFFF, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_FREE, 16'd0, 12'hFFF, 1'b1);
    issue(fbfl_pkg::MODE_FREE, 16'd0, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'd4097, 12'd0, 1'b0);
    issue(fbfl_pkg::MODE_ALLOC, 16'd4096, 12'd0, 1'b0);

    for (int phase = 0; phase < 10; phase++) begin
      set_shift(phase_shifts[phase]);
      steady     = (phase % 3 == 1);
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 4 && i == PHASE_ITEMS / 2) wait_quiet();
        random_item();
      end
    end

    wait_quiet();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("fixed_block_free_list_allocator test passed");
    end else begin
      $display("fixed_block_free_list_allocator test failed");
    end
    $finish;
  end

endmodule
